// ===== hdl/round_robin_task_scheduler_macros.svh =====
// Assertion macros for the round-robin task scheduler checker.
// No dependencies; included by the checker file only, which supplies i_clk and i_rst_n.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== hdl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by the controller, the datapath and the top level.
package rrts_pkg;

    localparam int DEF_NUM_TASKS = 8;
    localparam int TICK_W        = 32;
    localparam int TASK_ID_W     = 3;
    localparam int MASK_W        = 8;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_DELAY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_TICK,
        S_DELAY,
        S_PICK,
        S_DONE
    } t_state;

    typedef struct packed {
        logic start;
        logic scan;
        logic delay;
        logic pick;
        logic emit;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_done;
        logic pick_done;
    } t_dp_sts;

endpackage

// ===== hdl/rrts_ctrl.sv =====
// Sequencing state machine for the round-robin task scheduler.
// Depends on rrts_pkg; drives rrts_dp through command and status structs.
module rrts_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic              i_op,
    input  rrts_pkg::t_dp_sts i_sts,
    output rrts_pkg::t_dp_cmd o_cmd,
    output logic              o_busy
);
    import rrts_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.start = 1'b1;
                    n_state     = (i_op == OP_DELAY) ? S_DELAY : S_TICK;
                end
            end
            S_TICK: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_PICK;
                end
            end
            S_DELAY: begin
                o_cmd.delay = 1'b1;
                n_state     = S_PICK;
            end
            S_PICK: begin
                o_cmd.pick = 1'b1;
                if (i_sts.pick_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ===== hdl/rrts_dp.sv =====
// Datapath of the round-robin task scheduler: tick counter, ready marks,
// wake tick memory, round-robin pointer and result registers. Depends on rrts_pkg.
module rrts_dp #(
    parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rrts_pkg::t_dp_cmd              i_cmd,
    input  logic                           i_op,
    input  logic [rrts_pkg::TICK_W-1:0]    i_delay_ticks,
    output rrts_pkg::t_dp_sts              o_sts,
    output logic                           o_valid,
    output logic [rrts_pkg::TASK_ID_W-1:0] o_running_task,
    output logic [rrts_pkg::TICK_W-1:0]    o_tick_now,
    output logic [rrts_pkg::MASK_W-1:0]    o_ready_mask
);
    import rrts_pkg::*;

    localparam int IW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
    localparam int CW = $clog2(NUM_TASKS + 1);

    logic [TICK_W-1:0]    r_tick;
    logic [NUM_TASKS-1:0] r_ready;
    logic [IW-1:0]        r_cur;
    logic [CW-1:0]        r_idx;
    logic                 r_chk_vld;
    logic [CW-1:0]        r_k;
    logic [IW-1:0]        r_cand;
    logic [TICK_W-1:0]    r_delay;
    logic [TICK_W-1:0]    r_rd_data;
    logic [IW-1:0]        r_rd_idx;
    logic [TICK_W-1:0]    r_wake_mem [NUM_TASKS];

    logic                 r_valid;
    logic [TASK_ID_W-1:0] r_out_task;
    logic [TICK_W-1:0]    r_out_tick;
    logic [MASK_W-1:0]    r_out_mask;

    logic                 w_idx_live;
    logic                 w_hit;
    logic                 w_k_last;
    logic [IW+2:0]        w_cur_ext;
    logic [NUM_TASKS+7:0] w_ready_ext;

    function automatic logic [IW-1:0] f_next(input logic [IW-1:0] v);
        logic [IW-1:0] res;
        if (v == IW'(NUM_TASKS - 1)) begin
            res = '0;
        end else begin
            res = v + IW'(1);
        end
        return res;
    endfunction

    assign w_idx_live = (r_idx != CW'(NUM_TASKS));
    assign w_hit      = (r_cand != '0) && r_ready[r_cand];
    assign w_k_last   = (r_k == CW'(NUM_TASKS));

    assign o_sts.scan_done = !w_idx_live && r_chk_vld;
    assign o_sts.pick_done = w_hit || w_k_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick    <= '0;
            r_ready   <= '1;
            r_cur     <= IW'(1);
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_k       <= '0;
            r_cand    <= '0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.emit;
            if (i_cmd.start) begin
                r_idx     <= CW'(1);
                r_chk_vld <= 1'b0;
                r_k       <= CW'(1);
                r_cand    <= f_next(r_cur);
                if (i_op == OP_TICK) begin
                    r_tick <= r_tick + TICK_W'(1);
                end
            end
            if (i_cmd.scan) begin
                if (w_idx_live) begin
                    r_idx     <= r_idx + CW'(1);
                    r_chk_vld <= 1'b1;
                end else begin
                    r_chk_vld <= 1'b0;
                end
                // wake on the tick that reaches the stored wake tick
                if (r_chk_vld && !r_ready[r_rd_idx] && (r_rd_data <= r_tick)) begin
                    r_ready[r_rd_idx] <= 1'b1;
                end
            end
            if (i_cmd.delay && (r_cur != '0)) begin
                r_ready[r_cur] <= 1'b0;
            end
            if (i_cmd.pick) begin
                if (w_hit) begin
                    r_cur <= r_cand;
                end else if (w_k_last) begin
                    r_cur <= '0;
                end else begin
                    r_cand <= f_next(r_cand);
                    r_k    <= r_k + CW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_delay <= i_delay_ticks;
        end
        if (i_cmd.scan && w_idx_live) begin
            r_rd_data <= r_wake_mem[r_idx[IW-1:0]];
            r_rd_idx  <= r_idx[IW-1:0];
        end
        if (i_cmd.delay && (r_cur != '0)) begin
            r_wake_mem[r_cur] <= r_delay + r_tick;
        end
    end

    assign w_cur_ext   = {3'b000, r_cur};
    assign w_ready_ext = {8'h00, r_ready};

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_task <= w_cur_ext[TASK_ID_W-1:0];
            r_out_tick <= r_tick;
            r_out_mask <= w_ready_ext[MASK_W-1:0];
        end
    end

    assign o_valid        = r_valid;
    assign o_running_task = r_out_task;
    assign o_tick_now     = r_out_tick;
    assign o_ready_mask   = r_out_mask;

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler, top level. A tick request runs the wake-tick scan, then the
// round-robin search of 1..N tasks; a delay request writes its wake tick, then searches.
// No request is taken while one runs; start is taken again in the cycle o_valid shows.
// The wake-tick scan reads one memory entry a cycle and the search checks one task a cycle.
// Synchronous active-low reset: tick 0, every task ready, task 1 running, no clearing pass.
// The receiver cannot stall: each result is flagged by o_valid for one cycle only.
module round_robin_task_scheduler #(
    parameter int NUM_TASKS = rrts_pkg::DEF_NUM_TASKS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_op,
    input  logic [rrts_pkg::TICK_W-1:0]    i_delay_ticks,
    output logic                           o_valid,
    output logic [rrts_pkg::TASK_ID_W-1:0] o_running_task,
    output logic [rrts_pkg::TICK_W-1:0]    o_tick_now,
    output logic [rrts_pkg::MASK_W-1:0]    o_ready_mask
);
    import rrts_pkg::*;

    // Command and status between the sequencer and the datapath
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;

    // Sequencer: accept the request, then walk the tick scan or the delay
    // write, then the round-robin search, then emit the result.
    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_op    (i_op),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    // Datapath: hold the tick counter, ready marks and wake ticks; the wake
    // ticks live in a single-port memory, read once for each task but task 0 during a tick.
    // Task 0 (idle) is never blocked, so its ready mark stays set.
    rrts_dp #(
        .NUM_TASKS (NUM_TASKS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_op           (i_op),
        .i_delay_ticks  (i_delay_ticks),
        .o_sts          (w_sts),
        .o_valid        (o_valid),
        .o_running_task (o_running_task),
        .o_tick_now     (o_tick_now),
        .o_ready_mask   (o_ready_mask)
    );

endmodule

// ===== hdl/rrts_chk.sv =====
// Port-level checker for the round-robin task scheduler, bound to the top level.
// Depends on round_robin_task_scheduler_macros.svh.
`include "round_robin_task_scheduler_macros.svh"

module rrts_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_start,
    input logic       i_busy,
    input logic       i_valid,
    input logic [7:0] i_ready_mask
);

    `RRTS_ASSERT_NEXT(a_accept_busy, i_start && !i_busy, i_busy, "busy low after accept")
    `RRTS_ASSERT_SAME(a_valid_after_busy, i_valid, $past(i_busy), "strobe without request")
    `RRTS_ASSERT_SAME(a_valid_single, i_valid, !$past(i_valid), "strobe repeated")
    `RRTS_ASSERT_SAME(a_idle_ready, i_valid, i_ready_mask[0], "idle task shown blocked")

endmodule

bind round_robin_task_scheduler rrts_chk u_rrts_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_start      (start),
    .i_busy       (busy),
    .i_valid      (o_valid),
    .i_ready_mask (o_ready_mask)
);
